>>> design/periodic_lattice_index_map_defines.svh
// assertion macros for the periodic lattice index map
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef PERIODIC_LATTICE_INDEX_MAP_DEFINES_SVH
`define PERIODIC_LATTICE_INDEX_MAP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PLIM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PLIM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/plim_pkg.sv
// shared constants, codes, types and helpers for the periodic lattice index map
// no dependencies
`timescale 1ns / 1ps
package plim_pkg;

  localparam int CMD_W      = 2;
  localparam int COORD_W    = 16;
  localparam int INDEX_W    = 26;
  localparam int POS_W      = 9;
  localparam int DIST_W     = 18;
  localparam int ERR_W      = 2;
  localparam int DIM_W      = 8;
  localparam int MOD_W      = 9;   // wrapped component, below twice the largest dim
  localparam int DIFF_W     = 11;
  localparam int SQ_W       = 16;
  localparam int T1_W       = 16;
  localparam int SC_W       = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int DIM_MAX    = 255;

  localparam int DIV_NUM_W  = 26;
  localparam int DIV_DEN_W  = 16;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = DIV_NUM_W / DIV_STEPS;

  localparam logic [CMD_W-1:0] CMD_TO_INDEX = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TO_COORD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DIST     = 2'd2;

  localparam logic [ERR_W-1:0] ERR_OK     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_PARITY = 2'd1;
  localparam logic [ERR_W-1:0] ERR_RANGE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LATTICE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_X   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_Y   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_Z   = 2'd3;

  // item state between the divider section and the output section
  typedef struct packed {
    logic [CMD_W-1:0]            cmd;
    logic                        fcc;
    logic                        range_err;
    logic [DIM_W-1:0]            z;
    logic [1:0]                  rb;
    logic [2:0][MOD_W-1:0]       wc;
    logic [2:0][MOD_W-1:0]       wo;
  } mid_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    r = d;
    if (d == '0) r = DIM_W'(1);
    else if (int'(d) > DIM_MAX) r = DIM_W'(DIM_MAX);
    return r;
  endfunction

  // fcc basis offsets, returned as {z, y, x}
  function automatic logic [2:0] basis_offs(input logic [1:0] rb);
    logic [2:0] r;
    case (rb)
      2'd0:    r = 3'b000;
      2'd1:    r = 3'b110;
      2'd2:    r = 3'b101;
      2'd3:    r = 3'b011;
      default: r = 3'b000;
    endcase
    return r;
  endfunction

endpackage

>>> design/periodic_lattice_index_map.sv
// periodic lattice index map, top level
// depends on plim_pkg, plim_div, plim_post and periodic_lattice_index_map_defines.svh
//
//   channel  handshake                  payload
//   in       in_valid_i / in_stall_o    command, coord_*, other_*, site_index
//   out      out_valid_o / out_stall_i  index_out, pos_*, dist_sq, error
//   cfg      cfg_we_i                   cfg_index_i, cfg_data_i
//
// one beat in and one beat out per cycle while the output is not stalled; the path is an input
// register, two 13-stage dividers in series (floor modulo and index split, then the x/y split)
// and three output stages. reset clears the valid bits and sets the registers to
// cubic with all dims 1. a stalled output beat freezes the whole pipeline.
`timescale 1ns / 1ps
`include "periodic_lattice_index_map_defines.svh"
module periodic_lattice_index_map (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [plim_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [plim_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [plim_pkg::CMD_W-1:0]            command_i,
  input  logic signed [plim_pkg::COORD_W-1:0]   coord_x_i,
  input  logic signed [plim_pkg::COORD_W-1:0]   coord_y_i,
  input  logic signed [plim_pkg::COORD_W-1:0]   coord_z_i,
  input  logic signed [plim_pkg::COORD_W-1:0]   other_x_i,
  input  logic signed [plim_pkg::COORD_W-1:0]   other_y_i,
  input  logic signed [plim_pkg::COORD_W-1:0]   other_z_i,
  input  logic [plim_pkg::INDEX_W-1:0]          site_index_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [plim_pkg::INDEX_W-1:0]          index_out_o,
  output logic [plim_pkg::POS_W-1:0]            pos_x_o,
  output logic [plim_pkg::POS_W-1:0]            pos_y_o,
  output logic [plim_pkg::POS_W-1:0]            pos_z_o,
  output logic [plim_pkg::DIST_W-1:0]           dist_sq_o,
  output logic [plim_pkg::ERR_W-1:0]            error_o
);

  localparam int LastStage = plim_pkg::DIV_STAGES - 1;

  typedef struct packed {
    logic [plim_pkg::CMD_W-1:0] cmd;
    logic                       fcc;
    logic [5:0]                 sgn;
    logic [1:0]                 rb;
  } sb_t;

  // configuration
  logic                                 lattice_q;
  logic [2:0][plim_pkg::DIM_W-1:0]      dim_q;
  logic [2:0][plim_pkg::DIM_W-1:0]      dcl;
  logic [2:0][plim_pkg::MOD_W-1:0]      modulus;
  logic [plim_pkg::DIV_DEN_W-1:0]       plane;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lattice_q <= 1'b0;
      dim_q     <= {3{plim_pkg::DIM_W'(1)}};
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        plim_pkg::CFG_LATTICE: lattice_q <= cfg_data_i[0];
        plim_pkg::CFG_DIM_X:   dim_q[0]  <= cfg_data_i;
        plim_pkg::CFG_DIM_Y:   dim_q[1]  <= cfg_data_i;
        plim_pkg::CFG_DIM_Z:   dim_q[2]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // user must change registers only with nothing in flight (unchecked); stages read them live
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dcl[a]     = plim_pkg::clamp_dim(dim_q[a]);
      modulus[a] = lattice_q ? {dcl[a], 1'b0} : {1'b0, dcl[a]};
    end
    plane = plim_pkg::DIV_DEN_W'(dcl[0]) * plim_pkg::DIV_DEN_W'(dcl[1]);
  end

  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // input register: magnitudes and signs for floor modulo
  logic                                  s0_valid_q;
  logic [plim_pkg::CMD_W-1:0]            s0_cmd_q;
  logic [5:0][plim_pkg::COORD_W-1:0]     s0_mag_q;
  logic [5:0]                            s0_sgn_q;
  logic [plim_pkg::INDEX_W-1:0]          s0_idx_q;
  logic [5:0][plim_pkg::COORD_W-1:0]     in_comp;

  assign in_comp = {other_z_i, other_y_i, other_x_i, coord_z_i, coord_y_i, coord_x_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_cmd_q <= command_i;
      s0_idx_q <= site_index_i;
      for (int i = 0; i < 6; i++) begin
        s0_sgn_q[i] <= in_comp[i][plim_pkg::COORD_W-1];
        s0_mag_q[i] <= in_comp[i][plim_pkg::COORD_W-1] ? plim_pkg::COORD_W'(-in_comp[i])
                                                       : in_comp[i];
      end
    end
  end

  // first divider bank: six floor-modulo units and the index split by the plane size
  logic [5:0][plim_pkg::DIV_NUM_W-1:0]  mq;
  logic [5:0][plim_pkg::DIV_DEN_W-1:0]  mr;
  logic [plim_pkg::DIV_NUM_W-1:0]       iq, inum;
  logic [plim_pkg::DIV_DEN_W-1:0]       ir;

  for (genvar i = 0; i < 6; i++) begin : g_mod
    plim_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (plim_pkg::DIV_NUM_W'(s0_mag_q[i])),
      .den_i (plim_pkg::DIV_DEN_W'(modulus[i % 3])),
      .quo_o (mq[i]),
      .rem_o (mr[i])
    );
  end

  assign inum = lattice_q ? {2'b00, s0_idx_q[plim_pkg::INDEX_W-1:2]} : s0_idx_q;

  plim_div u_div_plane (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (inum),
    .den_i (plane),
    .quo_o (iq),
    .rem_o (ir)
  );

  sb_t  sb_q [plim_pkg::DIV_STAGES];
  logic v1_q [plim_pkg::DIV_STAGES];
  sb_t  sb_d;

  always_comb begin
    sb_d.cmd = s0_cmd_q;
    sb_d.fcc = lattice_q;
    sb_d.sgn = s0_sgn_q;
    sb_d.rb  = lattice_q ? s0_idx_q[1:0] : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < plim_pkg::DIV_STAGES; s++) v1_q[s] <= 1'b0;
    end else if (en) begin
      v1_q[0] <= s0_valid_q;
      for (int s = 1; s < plim_pkg::DIV_STAGES; s++) v1_q[s] <= v1_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q[0] <= sb_d;
      for (int s = 1; s < plim_pkg::DIV_STAGES; s++) sb_q[s] <= sb_q[s-1];
    end
  end

  // negative operands with a nonzero remainder fold back from the modulus
  plim_pkg::mid_t mid_d;

  always_comb begin
    logic [plim_pkg::MOD_W-1:0] r;
    mid_d.cmd       = sb_q[LastStage].cmd;
    mid_d.fcc       = sb_q[LastStage].fcc;
    mid_d.rb        = sb_q[LastStage].rb;
    mid_d.range_err = iq >= plim_pkg::DIV_NUM_W'(dcl[2]);
    mid_d.z         = iq[plim_pkg::DIM_W-1:0];
    for (int i = 0; i < 6; i++) begin
      r = mr[i][plim_pkg::MOD_W-1:0];
      if (sb_q[LastStage].sgn[i] && r != '0) r = modulus[i % 3] - r;
      if (i < 3) mid_d.wc[i] = r;
      else       mid_d.wo[i-3] = r;
    end
  end

  // second divider: remainder within the plane split into y and x
  logic [plim_pkg::DIV_NUM_W-1:0] yq;
  logic [plim_pkg::DIV_DEN_W-1:0] xr;

  plim_div u_div_row (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (plim_pkg::DIV_NUM_W'(ir)),
    .den_i (plim_pkg::DIV_DEN_W'(dcl[0])),
    .quo_o (yq),
    .rem_o (xr)
  );

  plim_pkg::mid_t mid_q [plim_pkg::DIV_STAGES];
  logic           v2_q  [plim_pkg::DIV_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < plim_pkg::DIV_STAGES; s++) v2_q[s] <= 1'b0;
    end else if (en) begin
      v2_q[0] <= v1_q[LastStage];
      for (int s = 1; s < plim_pkg::DIV_STAGES; s++) v2_q[s] <= v2_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mid_q[0] <= mid_d;
      for (int s = 1; s < plim_pkg::DIV_STAGES; s++) mid_q[s] <= mid_q[s-1];
    end
  end

  plim_post u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (v2_q[LastStage]),
    .mid_i       (mid_q[LastStage]),
    .x_i         (xr[plim_pkg::DIM_W-1:0]),
    .y_i         (yq[plim_pkg::DIM_W-1:0]),
    .dim_i       (dcl),
    .modulus_i   (modulus),
    .valid_o     (out_valid_o),
    .index_out_o (index_out_o),
    .pos_x_o     (pos_x_o),
    .pos_y_o     (pos_y_o),
    .pos_z_o     (pos_z_o),
    .dist_sq_o   (dist_sq_o),
    .error_o     (error_o)
  );

  `PLIM_ASSERT_IMPL(a_err_no_dist, out_valid_o && (error_o != plim_pkg::ERR_OK), dist_sq_o == '0, "error beat carries a distance")
  `PLIM_ASSERT_IMPL(a_range_clear, out_valid_o && (error_o == plim_pkg::ERR_RANGE), (pos_x_o == '0) && (pos_y_o == '0) && (pos_z_o == '0) && (index_out_o == '0), "range error beat carries data")
  `PLIM_ASSERT_IMPL(a_cubic_parity, out_valid_o && !lattice_q, error_o != plim_pkg::ERR_PARITY, "parity error on a cubic lattice")

endmodule

>>> design/plim_div.sv
// pipelined restoring divider, two quotient bits per stage
// depends on plim_pkg
`timescale 1ns / 1ps
module plim_div (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [plim_pkg::DIV_NUM_W-1:0]     num_i,
  input  logic [plim_pkg::DIV_DEN_W-1:0]     den_i,
  output logic [plim_pkg::DIV_NUM_W-1:0]     quo_o,
  output logic [plim_pkg::DIV_DEN_W-1:0]     rem_o
);

  // acc holds the dividend bits still to come, quotient bits enter at the bottom
  logic [plim_pkg::DIV_NUM_W-1:0] acc_q [plim_pkg::DIV_STAGES];
  logic [plim_pkg::DIV_DEN_W-1:0] rem_q [plim_pkg::DIV_STAGES];
  logic [plim_pkg::DIV_DEN_W-1:0] den_q [plim_pkg::DIV_STAGES];

  for (genvar s = 0; s < plim_pkg::DIV_STAGES; s++) begin : g_stage
    logic [plim_pkg::DIV_NUM_W-1:0] acc_in, acc_d;
    logic [plim_pkg::DIV_DEN_W-1:0] rem_in, rem_d, den_in;

    if (s == 0) begin : g_first
      assign acc_in = num_i;
      assign rem_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign acc_in = acc_q[s-1];
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
    end

    always_comb begin
      logic [plim_pkg::DIV_DEN_W:0] trial;
      acc_d = acc_in;
      rem_d = rem_in;
      for (int k = 0; k < plim_pkg::DIV_STEPS; k++) begin
        trial = {rem_d, acc_d[plim_pkg::DIV_NUM_W-1]};
        acc_d = {acc_d[plim_pkg::DIV_NUM_W-2:0], 1'b0};
        if (trial >= {1'b0, den_in}) begin
          rem_d    = plim_pkg::DIV_DEN_W'(trial - {1'b0, den_in});
          acc_d[0] = 1'b1;
        end else begin
          rem_d = trial[plim_pkg::DIV_DEN_W-1:0];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[s] <= acc_d;
        rem_q[s] <= rem_d;
        den_q[s] <= den_in;
      end
    end
  end

  assign quo_o = acc_q[plim_pkg::DIV_STAGES-1];
  assign rem_o = rem_q[plim_pkg::DIV_STAGES-1];

endmodule

>>> design/plim_post.sv
// output section: site index, minimum-image distance and coordinates, three stages
// depends on plim_pkg
`timescale 1ns / 1ps
module plim_post (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  plim_pkg::mid_t                        mid_i,
  input  logic [plim_pkg::DIM_W-1:0]            x_i,
  input  logic [plim_pkg::DIM_W-1:0]            y_i,
  input  logic [2:0][plim_pkg::DIM_W-1:0]       dim_i,
  input  logic [2:0][plim_pkg::MOD_W-1:0]       modulus_i,
  output logic                                  valid_o,
  output logic [plim_pkg::INDEX_W-1:0]          index_out_o,
  output logic [plim_pkg::POS_W-1:0]            pos_x_o,
  output logic [plim_pkg::POS_W-1:0]            pos_y_o,
  output logic [plim_pkg::POS_W-1:0]            pos_z_o,
  output logic [plim_pkg::DIST_W-1:0]           dist_sq_o,
  output logic [plim_pkg::ERR_W-1:0]            error_o
);

  // stage 1
  logic                                 v1_q;
  logic [plim_pkg::CMD_W-1:0]           cmd1_q;
  logic                                 fcc1_q;
  logic [plim_pkg::ERR_W-1:0]           err1_q, err1_d;
  logic [1:0]                           basis1_q, basis1_d;
  logic [plim_pkg::DIM_W-1:0]           cell0_1_q;
  logic [plim_pkg::T1_W-1:0]            t1_q, t1_d;
  logic [2:0][plim_pkg::DIM_W-1:0]      av_q, av_d;
  logic [2:0][plim_pkg::POS_W-1:0]      pos1_q, pos1_d;
  logic [2:0][plim_pkg::DIM_W-1:0]      cell_w;

  always_comb begin
    logic signed [plim_pkg::DIFF_W-1:0]  diff, v;
    logic signed [plim_pkg::DIFF_W:0]    two, nn;
    logic [2:0]                          offs;
    logic [2:0][plim_pkg::DIM_W-1:0]     raw;
    for (int a = 0; a < 3; a++) begin
      cell_w[a] = mid_i.fcc ? mid_i.wc[a][plim_pkg::MOD_W-1:1]
                            : mid_i.wc[a][plim_pkg::DIM_W-1:0];
    end
    err1_d   = plim_pkg::ERR_OK;
    basis1_d = 2'd0;
    if (mid_i.fcc) begin
      case ({mid_i.wc[2][0], mid_i.wc[1][0], mid_i.wc[0][0]})
        3'b000:  basis1_d = 2'd0;
        3'b110:  basis1_d = 2'd1;
        3'b101:  basis1_d = 2'd2;
        3'b011:  basis1_d = 2'd3;
        default: basis1_d = 2'd0;
      endcase
      if (mid_i.cmd == plim_pkg::CMD_TO_INDEX &&
          !({mid_i.wc[2][0], mid_i.wc[1][0], mid_i.wc[0][0]} inside
            {3'b000, 3'b110, 3'b101, 3'b011})) begin
        err1_d = plim_pkg::ERR_PARITY;
      end
    end
    if (mid_i.cmd == plim_pkg::CMD_TO_COORD && mid_i.range_err) err1_d = plim_pkg::ERR_RANGE;

    t1_d = plim_pkg::T1_W'(cell_w[1]) +
           plim_pkg::T1_W'(dim_i[1]) * plim_pkg::T1_W'(cell_w[2]);

    // minimum image, an exact half-box difference stays as it is
    for (int a = 0; a < 3; a++) begin
      diff = $signed({2'b00, mid_i.wo[a]}) - $signed({2'b00, mid_i.wc[a]});
      nn   = $signed({3'b000, modulus_i[a]});
      two  = {diff, 1'b0};
      if (two < -nn)     v = diff + $signed({2'b00, modulus_i[a]});
      else if (two > nn) v = diff - $signed({2'b00, modulus_i[a]});
      else               v = diff;
      av_d[a] = plim_pkg::DIM_W'(v < 0 ? -v : v);
    end

    raw  = {mid_i.z, y_i, x_i};
    offs = plim_pkg::basis_offs(mid_i.rb);
    for (int a = 0; a < 3; a++) begin
      pos1_d[a] = mid_i.fcc ? {raw[a], offs[a]} : {1'b0, raw[a]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cmd1_q    <= mid_i.cmd;
      fcc1_q    <= mid_i.fcc;
      err1_q    <= err1_d;
      basis1_q  <= basis1_d;
      cell0_1_q <= cell_w[0];
      t1_q      <= t1_d;
      av_q      <= av_d;
      pos1_q    <= pos1_d;
    end
  end

  // stage 2
  logic                                 v2_q;
  logic [plim_pkg::CMD_W-1:0]           cmd2_q;
  logic                                 fcc2_q;
  logic [plim_pkg::ERR_W-1:0]           err2_q;
  logic [1:0]                           basis2_q;
  logic [plim_pkg::DIM_W-1:0]           cell0_2_q;
  logic [plim_pkg::SC_W-1:0]            t2_q;
  logic [2:0][plim_pkg::SQ_W-1:0]       sq_q;
  logic [2:0][plim_pkg::POS_W-1:0]      pos2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cmd2_q    <= cmd1_q;
      fcc2_q    <= fcc1_q;
      err2_q    <= err1_q;
      basis2_q  <= basis1_q;
      cell0_2_q <= cell0_1_q;
      t2_q      <= plim_pkg::SC_W'(dim_i[0]) * plim_pkg::SC_W'(t1_q);
      for (int a = 0; a < 3; a++) begin
        sq_q[a] <= plim_pkg::SQ_W'(av_q[a]) * plim_pkg::SQ_W'(av_q[a]);
      end
      pos2_q    <= pos1_q;
    end
  end

  // stage 3, output register
  logic                                 v3_q;
  logic [plim_pkg::INDEX_W-1:0]         index_q, index_d;
  logic [2:0][plim_pkg::POS_W-1:0]      pos3_q, pos3_d;
  logic [plim_pkg::DIST_W-1:0]          dist_q, dist_d;
  logic [plim_pkg::ERR_W-1:0]           err3_q;

  always_comb begin
    logic [plim_pkg::SC_W-1:0] sc;
    sc      = plim_pkg::SC_W'(cell0_2_q) + t2_q;
    index_d = '0;
    if (cmd2_q == plim_pkg::CMD_TO_INDEX && err2_q == plim_pkg::ERR_OK) begin
      index_d = fcc2_q ? {sc, basis2_q} : plim_pkg::INDEX_W'(sc);
    end
    pos3_d = '0;
    if (cmd2_q == plim_pkg::CMD_TO_COORD && err2_q == plim_pkg::ERR_OK) pos3_d = pos2_q;
    dist_d = '0;
    if (cmd2_q == plim_pkg::CMD_DIST) begin
      dist_d = plim_pkg::DIST_W'(sq_q[0]) + plim_pkg::DIST_W'(sq_q[1]) +
               plim_pkg::DIST_W'(sq_q[2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      index_q <= index_d;
      pos3_q  <= pos3_d;
      dist_q  <= dist_d;
      err3_q  <= err2_q;
    end
  end

  assign valid_o     = v3_q;
  assign index_out_o = index_q;
  assign pos_x_o     = pos3_q[0];
  assign pos_y_o     = pos3_q[1];
  assign pos_z_o     = pos3_q[2];
  assign dist_sq_o   = dist_q;
  assign error_o     = err3_q;

endmodule
